// ----- src/dep_pkg.sv -----
// ----------------------------------------------------------------------------
// dep_pkg
// Shared types and constants for the double-ended priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dep_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CountW      = 7;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CountW-1:0]        count_t;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpDelMin = 2'd1,
    OpDelMax = 2'd2,
    OpNop    = 2'd3
  } op_e;

  // update command broadcast to every cell; at most one bit is set
  typedef struct packed {
    logic ins;
    logic del_min;
    logic del_max;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/double_ended_priority_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Sorted row of cells holding signed values; inserts and removes at either end
// and reports max, min, count, empty and dropped after every item.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  in      | in_valid_i / in_stall_o    | op_i, value_i
//  out     | out_valid_o / out_stall_i  | max_value_o, min_value_o, entry_count_o,
//          |                            | is_empty_o, dropped_o
//
// An item updates the cell row in the cycle it is accepted; its result is
// then taken from the row into the output register once that register is free.
// With the output free, one item per cycle; a result waiting on a stalled
// output holds off further items until it is passed to the output register.
// Reset empties the queue; cell contents are not cleared.
`default_nettype none

module double_ended_priority_queue #(
  parameter int unsigned CAPACITY = dep_pkg::DefCapacity
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire logic [1:0]      op_i,
  input  wire dep_pkg::value_t value_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      dep_pkg::value_t max_value_o,
  output      dep_pkg::value_t min_value_o,
  output      dep_pkg::count_t entry_count_o,
  output      logic            is_empty_o,
  output      logic            dropped_o
);
  import dep_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  value_t                cell_value [CAPACITY];
  value_t                cell_tap   [CAPACITY];
  logic   [CAPACITY-1:0] cell_valid;
  logic   [CAPACITY-1:0] cell_gt;

  cmd_t            cmd;
  logic            accept, load, full;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_drop_q, out_valid_q;
  value_t          max_q, min_q, max_or;
  count_t          count_q;
  logic            empty_q, drop_q;

  assign accept = in_valid_i && !in_stall_o;
  assign full   = cell_valid[CAPACITY-1];

  always_comb begin
    cmd = '0;
    if (accept) begin
      unique case (op_e'(op_i))
        OpInsert: cmd.ins     = !full;
        OpDelMin: cmd.del_min = 1'b1;
        OpDelMax: cmd.del_max = 1'b1;
        OpNop:    cmd         = '0;
        default:  cmd         = '0;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t prev_value, next_value;
    logic   prev_valid, prev_gt, next_valid;

    if (i == 0) begin : g_first
      assign prev_value = '0;
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_inner_prev
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner_next
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    dep_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .ins_value_i  (value_i),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .prev_gt_i    (prev_gt),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .gt_o         (cell_gt[i]),
      .top_tap_o    (cell_tap[i])
    );
  end

  // only the highest occupied cell drives its value on its tap; all other taps are zero
  always_comb begin
    max_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      max_or = max_or | cell_tap[i];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if ((cmd.del_min || cmd.del_max) && (cnt_q != '0)) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  assign load       = pend_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_q && !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_drop_q <= (op_e'(op_i) == OpInsert) && full;
    end
    if (load) begin
      max_q   <= max_or;
      min_q   <= cell_valid[0] ? cell_value[0] : '0;
      count_q <= CountW'(cnt_q);
      empty_q <= (cnt_q == '0);
      drop_q  <= pend_drop_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign max_value_o   = max_q;
  assign min_value_o   = min_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = empty_q;
  assign dropped_o     = drop_q;

`ifndef SYNTHESIS
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(cnt_q))
    else $error("occupied cells disagree with count");

  a_cells_packed_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) == cell_valid[0])
    else $error("occupied cells not packed from cell 0");

  a_drop_on_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_e'(op_i) == OpInsert) && full) |=> (pend_drop_q && $stable(cnt_q)))
    else $error("insert into full queue not flagged or changed count");
`endif

endmodule

`default_nettype wire

// ----- src/dep_cell.sv -----
// ----------------------------------------------------------------------------
// dep_cell
// One slot of the sorted cell row: holds a value and an occupied bit, and
// shifts towards either neighbour on insert or delete-minimum; on delete-maximum the top occupied slot frees itself.
// ----------------------------------------------------------------------------
`default_nettype none

module dep_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dep_pkg::cmd_t   cmd_i,
  input  wire dep_pkg::value_t ins_value_i,
  input  wire dep_pkg::value_t prev_value_i,
  input  wire logic            prev_valid_i,
  input  wire logic            prev_gt_i,
  input  wire dep_pkg::value_t next_value_i,
  input  wire logic            next_valid_i,
  output      dep_pkg::value_t value_o,
  output      logic            valid_o,
  output      logic            gt_o,
  output      dep_pkg::value_t top_tap_o
);
  import dep_pkg::*;

  value_t value_q, value_d;
  logic   valid_q, valid_d;
  logic   gt;

  // slot is free or holds a value above the one being inserted
  assign gt = !valid_q || (ins_value_i < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (cmd_i.ins) begin
      if (gt) begin
        value_d = prev_gt_i ? prev_value_i : ins_value_i;
        valid_d = prev_valid_i;
      end
    end else if (cmd_i.del_min) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end else if (cmd_i.del_max) begin
      valid_d = valid_q && next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o   = value_q;
  assign valid_o   = valid_q;
  assign gt_o      = gt;
  assign top_tap_o = (valid_q && !next_valid_i) ? value_q : '0;

endmodule

`default_nettype wire

// ----- tb/double_ended_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_priority_queue_tb
// Drives random and directed insert / delete-min / delete-max items through the
// queue under varying input gaps and output stalls. A sorted shadow copy of
// the contents predicts max, min, count, empty and dropped for each item.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_tb;
  import dep_pkg::*;

  localparam int unsigned Capacity   = DefCapacity;
  localparam int unsigned ItemsPerPh = 425;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    value_t max_value;
    value_t min_value;
    count_t entry_count;
    logic   is_empty;
    logic   dropped;
  } report_t;

  class sorted_store_checker;
    value_t  contents[$];
    report_t expected_reports[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    function void note_op(op_e op, value_t v);
      report_t r;
      int      pos;
      r.dropped = 1'b0;
      case (op)
        OpInsert: begin
          if (contents.size() >= Capacity) begin
            r.dropped = 1'b1;
          end else begin
            pos = 0;
            while (pos < contents.size() && !(v < contents[pos])) pos++;
            contents.insert(pos, v);
          end
        end
        OpDelMin: if (contents.size() > 0) contents.delete(0);
        OpDelMax: if (contents.size() > 0) contents.delete(contents.size() - 1);
        default: ;
      endcase
      if (contents.size() == 0) begin
        r.max_value = '0;
        r.min_value = '0;
      end else begin
        r.max_value = contents[contents.size()-1];
        r.min_value = contents[0];
      end
      r.entry_count = count_t'(contents.size());
      r.is_empty    = (contents.size() == 0);
      expected_reports = {expected_reports, r};
    endfunction

    function void compare(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_report(report_t got);
      report_t exp_r;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got max %0d min %0d count %0d",
                 $time, got.max_value, got.min_value, got.entry_count);
      end else begin
        exp_r = expected_reports[0];
        expected_reports.delete(0);
        compare("max_value", exp_r.max_value, got.max_value);
        compare("min_value", exp_r.min_value, got.min_value);
        compare("entry_count", exp_r.entry_count, got.entry_count);
        compare("is_empty", exp_r.is_empty, got.is_empty);
        compare("dropped", exp_r.dropped, got.dropped);
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  logic [1:0] op_i;
  value_t value_i;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  value_t max_value_o;
  value_t min_value_o;
  count_t entry_count_o;
  logic   is_empty_o;
  logic   dropped_o;

  sorted_store_checker checker_h = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt = 0;

  double_ended_priority_queue #(
    .CAPACITY(Capacity)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .max_value_o  (max_value_o),
    .min_value_o  (min_value_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .dropped_o    (dropped_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checker_h.check_report({max_value_o, min_value_o, entry_count_o, is_empty_o,
                              dropped_o});
    end
  end

  task automatic send_item(op_e op, value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    checker_h.note_op(op, v);
    @(negedge clk_i);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return value_t'($signed($urandom_range(16)) - 8);
      default: return value_t'($urandom);
    endcase
  endfunction

  // fill, drain and mixed runs so the queue swings between empty and full
  task automatic random_items(int unsigned n);
    int unsigned done;
    int unsigned seg_len;
    int unsigned mode;
    int unsigned ins_pct;
    int unsigned r;
    op_e         op;
    done = 0;
    while (done < n) begin
      seg_len = $urandom_range(40, 140);
      mode    = $urandom_range(2);
      ins_pct = (mode == 0) ? 82 : (mode == 1) ? 15 : 50;
      for (int unsigned k = 0; k < seg_len && done < n; k++) begin
        r = $urandom_range(99);
        if (r < ins_pct) op = OpInsert;
        else if (r >= 97) op = OpNop;
        else if ($urandom_range(1) == 0) op = OpDelMin;
        else op = OpDelMax;
        send_item(op, pick_value());
        done++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = OpNop;
    value_i        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // deletes and no-op on an empty queue, extremes, duplicates
    send_item(OpDelMin, 32'sh0);
    send_item(OpDelMax, 32'sh0);
    send_item(OpNop, 32'sh5a5a_5a5a);
    send_item(OpInsert, 32'sh7fff_ffff);
    send_item(OpInsert, 32'sh8000_0000);
    send_item(OpInsert, 32'sh0);
    send_item(OpInsert, -32'sd1);
    send_item(OpInsert, 32'sh7fff_ffff);
    send_item(OpInsert, -32'sd1);
    send_item(OpNop, 32'shffff_ffff);
    send_item(OpDelMin, 32'shffff_ffff);
    send_item(OpDelMax, 32'sh1234_5678);
    send_item(OpDelMax, 32'sh0);
    send_item(OpDelMin, 32'sh0);
    send_item(OpDelMax, 32'sh0);
    send_item(OpDelMin, 32'sh0);
    send_item(OpDelMin, 32'sh0);
    send_item(OpInsert, 32'sh1);
    send_item(OpDelMax, 32'sh0);
    send_item(OpDelMax, 32'sh0);

    random_items(ItemsPerPh);
    send_idle_pct = 54;
    random_items(ItemsPerPh);
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    random_items(ItemsPerPh);
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    random_items(ItemsPerPh);

    in_valid_i <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (checker_h.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
